// File: design/rfcd_pkg.sv
// ----------------------------------------------------------------------------
// rfcd_pkg
// Shared constants and types for the remote frame channel decoder.
// ----------------------------------------------------------------------------
package rfcd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam int BYTE_W      = 8;
    localparam int CH_W        = 11;
    localparam int SW_W        = 2;
    localparam int NUM_CH      = 4;
    localparam int CFG_IDX_W   = 1;

    // fixed byte positions inside a frame
    localparam int SW_BYTE_IDX   = 5;
    localparam int WHEEL_LO_IDX  = 16;
    localparam int WHEEL_HI_IDX  = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MAX = 1'b1;

    localparam logic [CH_W-1:0] CH_MIN_RESET = 11'd364;
    localparam logic [CH_W-1:0] CH_MAX_RESET = 11'd1684;
    localparam logic [CH_W-1:0] CH_RESET     = 11'd1024;
    localparam logic [SW_W-1:0] SW_UP        = 2'd1;
    localparam logic [SW_W-1:0] SW_NONE      = 2'd0;

    // frame bytes the decoder looks at
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic [BYTE_W-1:0] b4;
        logic [BYTE_W-1:0] b5;
        logic [BYTE_W-1:0] b16;
        logic [BYTE_W-1:0] b17;
    } t_frame_view;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] ch;
        logic [SW_W-1:0]             sw_l;
        logic [SW_W-1:0]             sw_r;
        logic [CH_W-1:0]             wheel;
        logic                        pass;
    } t_decoded;

endpackage

// File: design/rfcd_frame_store.sv
// ----------------------------------------------------------------------------
// rfcd_frame_store
// Byte position counter and frame byte registers; presents the bytes the
// decoder needs, with the beat being written overlaid on the stored copy.
// ----------------------------------------------------------------------------
module rfcd_frame_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic                        i_frame_start,
    input  logic [rfcd_pkg::BYTE_W-1:0] i_data_byte,
    output logic                        o_last,
    output rfcd_pkg::t_frame_view       o_view
);
    import rfcd_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  w_pos_eff;
    logic              w_in_range;
    logic [IDX_W-1:0]  w_idx;
    logic [BYTE_W-1:0] r_store [FRAME_BYTES];

    function automatic logic [BYTE_W-1:0] pick(input logic [IDX_W-1:0] k);
        logic hit;
        hit = w_in_range && (w_idx == k);
        return hit ? i_data_byte : r_store[k];
    endfunction

    assign w_pos_eff  = i_frame_start ? '0 : r_pos;
    assign w_in_range = (w_pos_eff < POS_W'(FRAME_BYTES));
    assign w_idx      = w_pos_eff[IDX_W-1:0];
    assign o_last     = (w_pos_eff == POS_W'(FRAME_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_wr) begin
            // saturates at FRAME_BYTES until the next start flag
            r_pos <= w_in_range ? w_pos_eff + POS_W'(1) : w_pos_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && w_in_range) begin
            r_store[w_idx] <= i_data_byte;
        end
    end

    always_comb begin
        o_view.b0  = pick(IDX_W'(0));
        o_view.b1  = pick(IDX_W'(1));
        o_view.b2  = pick(IDX_W'(2));
        o_view.b3  = pick(IDX_W'(3));
        o_view.b4  = pick(IDX_W'(4));
        o_view.b5  = pick(IDX_W'(SW_BYTE_IDX));
        o_view.b16 = pick(IDX_W'(WHEEL_LO_IDX));
        o_view.b17 = pick(IDX_W'(WHEEL_HI_IDX));
    end

endmodule

// File: design/rfcd_unpack.sv
// ----------------------------------------------------------------------------
// rfcd_unpack
// Unpacks stick channels, switches and wheel from a frame and runs the
// range and switch checks.
// ----------------------------------------------------------------------------
module rfcd_unpack (
    input  rfcd_pkg::t_frame_view     i_view,
    input  logic [rfcd_pkg::CH_W-1:0] i_ch_min,
    input  logic [rfcd_pkg::CH_W-1:0] i_ch_max,
    output rfcd_pkg::t_decoded        o_dec
);
    import rfcd_pkg::*;

    logic [NUM_CH-1:0] w_ch_ok;

    always_comb begin
        o_dec.ch[0] = {i_view.b1[2:0], i_view.b0};
        o_dec.ch[1] = {i_view.b2[5:0], i_view.b1[7:3]};
        o_dec.ch[2] = {i_view.b4[0], i_view.b3, i_view.b2[7:6]};
        o_dec.ch[3] = {i_view.b5[3:0], i_view.b4[7:1]};
        o_dec.sw_l  = i_view.b5[7:6];
        o_dec.sw_r  = i_view.b5[5:4];
        o_dec.wheel = {i_view.b17[2:0], i_view.b16};

        for (int k = 0; k < NUM_CH; k++) begin
            w_ch_ok[k] = (o_dec.ch[k] >= i_ch_min) && (o_dec.ch[k] <= i_ch_max);
        end

        o_dec.pass = (&w_ch_ok) && (o_dec.sw_l != SW_NONE) && (o_dec.sw_r != SW_NONE);
    end

endmodule

// File: design/remote_frame_channel_decoder_top.sv
// ----------------------------------------------------------------------------
// remote_frame_channel_decoder_top
// Receiver frame decoder: collects frame bytes, unpacks and checks channels
// on the last byte, and holds the last good values.
//
//   channel   direction  handshake                    payload
//   input     in         i_valid / o_stall            i_data_byte, i_frame_start
//   result    out        o_valid / i_stall            held channels, switches,
//                                                     wheel, o_accepted
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One byte per cycle while o_stall is low. The last byte of a frame is unpacked
// and checked in the same cycle; its result beat is registered and shows in the next cycle.
// Synchronous active-low reset restores held values, bounds and position.
// o_stall rises only when a frame-completing byte meets a result beat that
// is still stalled; all other bytes are taken regardless. Config always ready.
// ----------------------------------------------------------------------------
module remote_frame_channel_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input bytes
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rfcd_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                           i_frame_start,
    // results
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rfcd_pkg::CH_W-1:0]      o_right_horizontal,
    output logic [rfcd_pkg::CH_W-1:0]      o_right_vertical,
    output logic [rfcd_pkg::CH_W-1:0]      o_left_horizontal,
    output logic [rfcd_pkg::CH_W-1:0]      o_left_vertical,
    output logic [rfcd_pkg::SW_W-1:0]      o_left_switch,
    output logic [rfcd_pkg::SW_W-1:0]      o_right_switch,
    output logic [rfcd_pkg::CH_W-1:0]      o_wheel,
    output logic                           o_accepted,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfcd_pkg::CH_W-1:0]      i_cfg_data
);
    import rfcd_pkg::*;

    logic                        r_out_valid;
    logic                        r_accepted;
    logic [NUM_CH-1:0][CH_W-1:0] r_held_ch;
    logic [SW_W-1:0]             r_held_sw_l;
    logic [SW_W-1:0]             r_held_sw_r;
    logic [CH_W-1:0]             r_held_wheel;
    logic [CH_W-1:0]             r_ch_min;
    logic [CH_W-1:0]             r_ch_max;

    logic        w_last;
    logic        w_in_acc;
    logic        w_load;
    logic        w_out_acc;
    t_frame_view w_view;
    t_decoded    w_dec;

    // only a completing byte needs the result register free
    assign o_stall   = r_out_valid && i_stall && w_last;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_load    = w_in_acc && w_last;
    assign w_out_acc = r_out_valid && !i_stall;

    rfcd_frame_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_in_acc),
        .i_frame_start (i_frame_start),
        .i_data_byte   (i_data_byte),
        .o_last        (w_last),
        .o_view        (w_view)
    );

    rfcd_unpack u_unpack (
        .i_view   (w_view),
        .i_ch_min (r_ch_min),
        .i_ch_max (r_ch_max),
        .o_dec    (w_dec)
    );

    // held values double as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_accepted   <= 1'b0;
            r_held_ch    <= {NUM_CH{CH_RESET}};
            r_held_sw_l  <= SW_UP;
            r_held_sw_r  <= SW_UP;
            r_held_wheel <= CH_RESET;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_accepted  <= w_dec.pass;
            if (w_dec.pass) begin
                r_held_ch    <= w_dec.ch;
                r_held_sw_l  <= w_dec.sw_l;
                r_held_sw_r  <= w_dec.sw_r;
                r_held_wheel <= w_dec.wheel;
            end
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_min <= CH_MIN_RESET;
            r_ch_max <= CH_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CH_MIN: r_ch_min <= i_cfg_data;
                CFG_CH_MAX: r_ch_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_right_horizontal = r_held_ch[0];
    assign o_right_vertical   = r_held_ch[1];
    assign o_left_horizontal  = r_held_ch[2];
    assign o_left_vertical    = r_held_ch[3];
    assign o_left_switch      = r_held_sw_l;
    assign o_right_switch     = r_held_sw_r;
    assign o_wheel            = r_held_wheel;
    assign o_accepted         = r_accepted;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result beat");

    a_accept_switches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_left_switch != SW_NONE && o_right_switch != SW_NONE))
        else $error("accepted frame carries a zero switch code");

    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> ($stable(o_right_horizontal) && $stable(o_left_vertical)
                     && $stable(o_wheel) && $stable(o_left_switch)))
        else $error("held values changed without a completed frame");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_dec.pass) |=> (!o_accepted && $stable(o_right_vertical)
                                     && $stable(o_right_switch)))
        else $error("rejected frame altered held values");

endmodule
